[sv/twg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_pkg
// Shared constants, types and the quarter-wave sine table of the tone generator.
// ----------------------------------------------------------------------------
package twg_pkg;

	localparam int ACC_BITS     = 32;
	localparam int QT_DEPTH     = 1024;
	localparam int SAMPLE_BITS  = 16;

	localparam int QT_BITS      = $clog2(QT_DEPTH);
	localparam int QT_ENTRIES   = QT_DEPTH + 1;
	localparam int QT_ADDR_BITS = $clog2(QT_ENTRIES);
	localparam int QUAD_SHIFT   = ACC_BITS - 2;

	localparam int MAG_BITS     = 15;
	localparam int FRAC_BITS    = 15;
	localparam int TW_BITS      = 32;
	localparam int PO_BITS      = 16;
	localparam int AMP_BITS     = 15;
	localparam int CNT_BITS     = 24;
	localparam int OUT_MAX      = (1 << (SAMPLE_BITS - 1)) - 1;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_TUNING_WORD  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_OFFSET = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_WAVE_MODE    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_COUNT = 3'd4;

	localparam logic [CNT_BITS-1:0] SAMPLE_COUNT_RESET = 24'd44100;

	// taylor series constants, q30
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef logic [MAG_BITS-1:0] qtab_t [QT_ENTRIES];

	typedef struct packed {
		logic                valid;
		logic                neg;
		logic                square;
		logic                last;
		logic [AMP_BITS-1:0] amp;
	} twg_s1_t;

	typedef struct packed {
		logic loaded;
		logic run_done;
	} twg_stat_t;

	// elaboration-time table build: horner steps in unsigned q30, truncating
	function automatic qtab_t build_qtab();
		qtab_t       tab;
		logic [63:0] theta;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		for (int k = 0; k < QT_ENTRIES; k++) begin
			theta = (64'(k) * HALF_PI_Q30 + 64'(QT_DEPTH / 2)) / QT_DEPTH;
			x2 = (theta * theta) >> 30;
			t = Q30_ONE;
			for (int i = 0; i < 6; i++) begin
				t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
			end
			v = (((theta * t) >> 30) + 64'd16384) >> 15;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			tab[k] = MAG_BITS'(v);
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// clip a magnitude to the largest positive sample
	function automatic logic [SAMPLE_BITS-2:0] sat_mag(input logic [31:0] v);
		logic [SAMPLE_BITS-2:0] r;
		if (v > 32'(OUT_MAX)) begin
			r = (SAMPLE_BITS-1)'(OUT_MAX);
		end else begin
			r = v[SAMPLE_BITS-2:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/twg_intf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg channel interfaces
// Tick input, sample output and configuration write channels.
// ----------------------------------------------------------------------------
interface twg_in_if;
	logic valid;
	logic ready;
	logic restart;
	modport source(output valid, output restart, input ready);
	modport sink(input valid, input restart, output ready);
endinterface

interface twg_out_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [twg_pkg::SAMPLE_BITS-1:0]    sample;
	logic                                      last;
	modport source(output valid, output sample, output last, input ready);
	modport sink(input valid, input sample, input last, output ready);
endinterface

interface twg_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [twg_pkg::CFG_IDX_BITS-1:0]    index;
	logic [twg_pkg::CFG_DATA_BITS-1:0]   data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/twg_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[sv/twg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_ctrl
// Config registers, phase accumulator and run state, table load sweep and
// the table address stage.
// ----------------------------------------------------------------------------
module twg_ctrl (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	twg_cfg_if.sink                                cfg,
	twg_in_if.sink                                 tick,
	input  wire logic                              advance,
	output      logic                              ram_we,
	output      logic [twg_pkg::QT_ADDR_BITS-1:0]  ram_waddr,
	output      logic [twg_pkg::MAG_BITS-1:0]      ram_wdata,
	output      logic [twg_pkg::QT_ADDR_BITS-1:0]  ram_raddr,
	output      twg_pkg::twg_s1_t                  s1,
	output      twg_pkg::twg_stat_t                stat
);

	logic [twg_pkg::TW_BITS-1:0]  tw_q;
	logic [twg_pkg::PO_BITS-1:0]  po_q;
	logic [twg_pkg::AMP_BITS-1:0] amp_q;
	logic                         mode_q;
	logic [twg_pkg::CNT_BITS-1:0] cnt_q;

	logic [twg_pkg::ACC_BITS-1:0] acc_q;
	logic [twg_pkg::CNT_BITS-1:0] idx_q;
	logic                         done_q;

	logic [twg_pkg::QT_ADDR_BITS-1:0] ld_q;
	logic                             ld_done_q;

	logic                         valid_s1;
	logic                         neg_s1;
	logic                         square_s1;
	logic                         last_s1;
	logic [twg_pkg::AMP_BITS-1:0] amp_s1;

	logic                         accept;
	logic [twg_pkg::ACC_BITS-1:0] acc_in;
	logic [twg_pkg::CNT_BITS-1:0] idx_in;
	logic [twg_pkg::CNT_BITS-1:0] idx_inc;
	logic                         done_in;
	logic                         emit;
	logic                         last;
	logic [twg_pkg::ACC_BITS-1:0] phase;
	logic [1:0]                   quad;
	logic [twg_pkg::QT_BITS-1:0]  k;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q   <= '0;
			po_q   <= '0;
			amp_q  <= '0;
			mode_q <= 1'b0;
			cnt_q  <= twg_pkg::SAMPLE_COUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				twg_pkg::REG_TUNING_WORD:  tw_q   <= cfg.data[twg_pkg::TW_BITS-1:0];
				twg_pkg::REG_PHASE_OFFSET: po_q   <= cfg.data[twg_pkg::PO_BITS-1:0];
				twg_pkg::REG_AMPLITUDE:    amp_q  <= cfg.data[twg_pkg::AMP_BITS-1:0];
				twg_pkg::REG_WAVE_MODE:    mode_q <= cfg.data[0];
				twg_pkg::REG_SAMPLE_COUNT: cnt_q  <= cfg.data[twg_pkg::CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// table load sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q      <= '0;
			ld_done_q <= 1'b0;
		end else if (!ld_done_q) begin
			if (ld_q == twg_pkg::QT_ADDR_BITS'(twg_pkg::QT_DEPTH)) begin
				ld_done_q <= 1'b1;
			end else begin
				ld_q <= ld_q + 1'b1;
			end
		end
	end

	assign ram_we    = !ld_done_q;
	assign ram_waddr = ld_q;
	assign ram_wdata = twg_pkg::QTAB[ld_q];

	assign tick.ready = ld_done_q && advance;
	assign accept     = tick.valid && tick.ready;

	always_comb begin
		acc_in  = tick.restart ? '0 : acc_q;
		idx_in  = tick.restart ? '0 : idx_q;
		done_in = tick.restart ? 1'b0 : done_q;
		emit    = !done_in && (idx_in < cnt_q);
		idx_inc = idx_in + 1'b1;
		last    = (idx_inc == cnt_q);
		phase   = acc_in + (twg_pkg::ACC_BITS'(po_q) << (twg_pkg::ACC_BITS - twg_pkg::PO_BITS));
		quad    = phase[twg_pkg::ACC_BITS-1 -: 2];
		k       = phase[twg_pkg::QUAD_SHIFT-1 -: twg_pkg::QT_BITS];
		// odd quadrants run the table backwards
		if (quad[0]) begin
			ram_raddr = twg_pkg::QT_ADDR_BITS'(twg_pkg::QT_DEPTH) - {1'b0, k};
		end else begin
			ram_raddr = {1'b0, k};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			idx_q  <= '0;
			done_q <= 1'b0;
		end else if (accept) begin
			if (emit) begin
				acc_q  <= acc_in + tw_q;
				idx_q  <= idx_inc;
				done_q <= last;
			end else begin
				acc_q  <= acc_in;
				idx_q  <= idx_in;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			neg_s1    <= quad[1];
			square_s1 <= mode_q;
			last_s1   <= last;
			amp_s1    <= amp_q;
		end
	end

	assign s1.valid  = valid_s1;
	assign s1.neg    = neg_s1;
	assign s1.square = square_s1;
	assign s1.last   = last_s1;
	assign s1.amp    = amp_s1;

	assign stat.loaded   = ld_done_q;
	assign stat.run_done = done_q;

endmodule
`default_nettype wire

[sv/twg_shape.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twg_shape
// Scales the table magnitude by the amplitude or forms the square wave, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module twg_shape (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire twg_pkg::twg_s1_t             s1,
	input  wire logic [twg_pkg::MAG_BITS-1:0] mag,
	twg_out_if.source                         result,
	output      logic                         advance
);

	localparam int PROD_BITS = twg_pkg::AMP_BITS + twg_pkg::MAG_BITS;
	localparam int P_BITS    = PROD_BITS + 1 - twg_pkg::FRAC_BITS;

	logic                                  out_valid_q;
	logic signed [twg_pkg::SAMPLE_BITS-1:0] sample_q;
	logic                                  last_q;

	logic [PROD_BITS-1:0]                  prod;
	logic [PROD_BITS:0]                    rnd;
	logic [P_BITS-1:0]                     p;
	logic [twg_pkg::SAMPLE_BITS-1:0]       sine_val;
	logic [twg_pkg::SAMPLE_BITS-1:0]       sq_val;
	logic                                  positive;
	logic signed [twg_pkg::SAMPLE_BITS-1:0] sample_d;

	always_comb begin
		prod     = PROD_BITS'(s1.amp) * PROD_BITS'(mag);
		rnd      = {1'b0, prod} + (PROD_BITS+1)'(1 << (twg_pkg::FRAC_BITS - 1));
		p        = rnd[PROD_BITS:twg_pkg::FRAC_BITS];
		sine_val = {1'b0, twg_pkg::sat_mag(32'(p))};
		sq_val   = {1'b0, twg_pkg::sat_mag(32'(s1.amp))};
		// a zero sine counts as not positive
		positive = !s1.neg && (mag != '0);
		if (s1.square) begin
			sample_d = positive ? sq_val : -sq_val;
		end else begin
			sample_d = s1.neg ? -sine_val : sine_val;
		end
	end

	assign advance = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1.valid) begin
			sample_q <= sample_d;
			last_q   <= s1.last;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.sample = sample_q;
	assign result.last   = last_q;

endmodule
`default_nettype wire

[sv/tone_waveform_generator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tone_waveform_generator_top
// Direct digital synthesis tone generator: sine or square, one sample a tick until the run ends.
// ----------------------------------------------------------------------------
//  channel   dir  payload                    transfer when
//  tick      in   restart                    tick.valid & tick.ready
//  result    out  sample (signed), last      result.valid & result.ready
//  cfg       in   index, data                cfg.valid & cfg.ready (always ready)
//
//  one tick per cycle while the result is not stalled; a tick's sample is
//  registered at the table read, then the scaling multiply fills the output register
//  after reset the quarter-wave table, all 1025 entries, is loaded into ram
//  with tick.ready low; config writes are taken during the load
//  a stalled result freezes the whole pipe, including the table read
// ----------------------------------------------------------------------------
module tone_waveform_generator_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	twg_in_if.sink     tick,
	twg_out_if.source  result,
	twg_cfg_if.sink    cfg
);

	logic                             ram_we;
	logic [twg_pkg::QT_ADDR_BITS-1:0] ram_waddr;
	logic [twg_pkg::MAG_BITS-1:0]     ram_wdata;
	logic [twg_pkg::QT_ADDR_BITS-1:0] ram_raddr;
	logic [twg_pkg::MAG_BITS-1:0]     ram_rdata;
	logic                             advance;
	twg_pkg::twg_s1_t                 s1;
	twg_pkg::twg_stat_t               stat;

	twg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.tick      (tick),
		.advance   (advance),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.s1        (s1),
		.stat      (stat)
	);

	twg_ram #(
		.WIDTH (twg_pkg::MAG_BITS),
		.DEPTH (twg_pkg::QT_ENTRIES)
	) u_qtab (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (advance),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	twg_shape u_shape (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1      (s1),
		.mag     (ram_rdata),
		.result  (result),
		.advance (advance)
	);

	// no tick transfer before the table is in place
	assert property (@(posedge clk) disable iff (!arst_n)
		tick.ready |-> stat.loaded)
		else $error("tick taken during table load");

	// a finished run without restart yields nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready && !tick.restart && stat.run_done) |=> !s1.valid)
		else $error("sample produced after end of run");

	// a restart always starts a sample when the run length is nonzero
	assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready && tick.restart && $past(1'b1) &&
		 !(cfg.valid && cfg.ready)) |=> (s1.valid || $past(u_ctrl.cnt_q) == '0))
		else $error("restart tick produced no sample");

	// a sample in flight comes from a loaded table
	assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid |-> stat.loaded)
		else $error("table read before load finished");

endmodule
`default_nettype wire

[verif/twg_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twg_tb_pkg
// Verification-side types and constants for the tone generator testbench.
// ----------------------------------------------------------------------------
package twg_tb_pkg;

	typedef enum logic {
		WAVE_SINE   = 1'b0,
		WAVE_SQUARE = 1'b1
	} wave_sel_e;

	// first of the unused register indexes, the rest up to the top of the field
	localparam logic [2:0] REG_NONE_LO = 3'd5;

	localparam int          QUARTER_STEPS   = 1024;
	localparam logic [63:0] UNIT_Q30        = 64'd1 << 30;
	localparam logic [63:0] RIGHT_ANGLE_Q30 = 64'd1686629713;
	localparam logic [63:0] HORNER_DIVISORS [6] = '{64'd156, 64'd110, 64'd72, 64'd42,
		64'd20, 64'd6};
	localparam int          PEAK_SAMPLE     = 32767;

	typedef struct packed {
		logic [15:0] level;
		logic        last;
	} tone_sample_t;

endpackage

[verif/twg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twg_checker
// Watches the tick, sample and register channels, predicts every sample of
// the tone generator and compares each sample transfer with the oldest one.
// ----------------------------------------------------------------------------
module twg_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	twg_in_if         tick,
	twg_out_if        result,
	twg_cfg_if        cfg,
	output int        errors,
	output int        pending
);
	import twg_pkg::*;
	import twg_tb_pkg::*;

	logic [14:0]  sine_quarter [0:QUARTER_STEPS];

	logic [31:0]  tw_reg;
	logic [15:0]  offset_reg;
	logic [14:0]  amp_reg;
	wave_sel_e    wave_sel;
	logic [23:0]  run_length;

	logic [31:0]  phase_acc;
	logic [23:0]  sample_idx;
	logic         run_over;

	tone_sample_t tone_queue [$];

	// degree-13 taylor sine in unsigned q30, truncating horner steps
	function automatic logic [63:0] taylor_sine_q30(input logic [63:0] theta);
		logic [63:0] x2;
		logic [63:0] t;
		x2 = (theta * theta) >> 30;
		t = UNIT_Q30;
		for (int i = 0; i < 6; i++) begin
			t = UNIT_Q30 - (((x2 * t) >> 30) / HORNER_DIVISORS[i]);
		end
		return (theta * t) >> 30;
	endfunction

	initial begin
		logic [63:0] theta;
		logic [63:0] v;
		for (int n = 0; n <= QUARTER_STEPS; n++) begin
			theta = (64'(n) * RIGHT_ANGLE_Q30 + 64'(QUARTER_STEPS / 2)) / 64'(QUARTER_STEPS);
			v = (taylor_sine_q30(theta) + 64'd16384) >> 15;
			sine_quarter[n] = (v > 64'(PEAK_SAMPLE)) ? 15'(PEAK_SAMPLE) : v[14:0];
		end
	end

	function automatic void predict_tick(input logic restart);
		logic [31:0]  phase;
		logic [1:0]   quad;
		logic [10:0]  k;
		logic [14:0]  mag;
		logic [31:0]  prod;
		logic [14:0]  m;
		tone_sample_t s;
		if (restart) begin
			sample_idx = '0;
			phase_acc = '0;
			run_over = 1'b0;
		end
		if (run_over) begin
			return;
		end
		// shrunken or zero length ends the run without a sample
		if (sample_idx >= run_length) begin
			run_over = 1'b1;
			return;
		end
		phase = phase_acc + {offset_reg, 16'h0000};
		quad = phase[31:30];
		k = {1'b0, phase[29:20]};
		if (quad[0]) begin
			k = 11'(QUARTER_STEPS) - k;
		end
		mag = sine_quarter[k];
		if (wave_sel == WAVE_SQUARE) begin
			// a zero sine counts as negative
			m = amp_reg;
			s.level = (!quad[1] && mag != 15'd0) ? {1'b0, m} : -{1'b0, m};
		end else begin
			prod = (32'(amp_reg) * 32'(mag) + 32'd16384) >> 15;
			m = (prod > 32'(PEAK_SAMPLE)) ? 15'(PEAK_SAMPLE) : prod[14:0];
			s.level = quad[1] ? -{1'b0, m} : {1'b0, m};
		end
		s.last = (25'(sample_idx) + 25'd1) == 25'(run_length);
		tone_queue.push_back(s);
		phase_acc = phase_acc + tw_reg;
		sample_idx = sample_idx + 24'd1;
		if (s.last) begin
			run_over = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tone_sample_t want;
		if (!arst_n) begin
			tw_reg = '0;
			offset_reg = '0;
			amp_reg = '0;
			wave_sel = WAVE_SINE;
			run_length = SAMPLE_COUNT_RESET;
			phase_acc = '0;
			sample_idx = '0;
			run_over = 1'b0;
			tone_queue.delete();
			errors = 0;
		end else begin
			// a sample transfer never belongs to a tick taken at the same edge
			if (result.valid && result.ready) begin
				if (tone_queue.size() == 0) begin
					$display("%0t: unexpected sample %0d last %0b", $time,
						$signed(result.sample), result.last);
					errors++;
				end else begin
					want = tone_queue.pop_front();
					if (result.sample !== want.level) begin
						$display("%0t: sample mismatch, expected %0d got %0d", $time,
							$signed(want.level), $signed(result.sample));
						errors++;
					end
					if (result.last !== want.last) begin
						$display("%0t: last mismatch, expected %0b got %0b", $time,
							want.last, result.last);
						errors++;
					end
				end
			end
			if (tick.valid && tick.ready) begin
				predict_tick(tick.restart);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_TUNING_WORD: tw_reg = cfg.data;
					REG_PHASE_OFFSET: offset_reg = cfg.data[15:0];
					REG_AMPLITUDE: amp_reg = cfg.data[14:0];
					REG_WAVE_MODE: wave_sel = wave_sel_e'(cfg.data[0]);
					REG_SAMPLE_COUNT: run_length = cfg.data[23:0];
					default: ;
				endcase
			end
		end
		pending = tone_queue.size();
	end

endmodule

[verif/tb_tone_waveform_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_waveform_generator_top
// Drives ticks and register writes into the tone generator with bursty input
// and a stalling sample sink; the checker predicts and compares each sample.
// ----------------------------------------------------------------------------
module tb_tone_waveform_generator_top;
	import twg_pkg::*;
	import twg_tb_pkg::*;

	localparam int TARGET_TICKS   = 850;
	localparam int IDLE_LIMIT     = 5000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   sent_ticks = 0;
	int   idle_cycles = 0;
	bit   hold_req = 1'b0;
	bit   gappy = 1'b0;
	int   burst_left = 0;

	twg_in_if  tick_ch();
	twg_out_if sample_ch();
	twg_cfg_if cfg_ch();

	tone_waveform_generator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (sample_ch),
		.cfg    (cfg_ch)
	);

	twg_checker tone_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_ch),
		.result   (sample_ch),
		.cfg      (cfg_ch),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// random junk above the register's width, half of the time
	function automatic logic [31:0] pad_junk(input logic [31:0] v, input int bits);
		logic [31:0] mask;
		mask = (32'd1 << bits) - 32'd1;
		return ($urandom_range(0, 1) != 0) ? ((v & mask) | ($urandom & ~mask)) : v;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= 3'($urandom);
		cfg_ch.data <= $urandom;
	endtask

	task automatic rest(input int cycles);
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		tick_ch.restart <= 1'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_tick(input logic restart);
		if (burst_left == 0) begin
			if (gappy) begin
				rest($urandom_range(1, 12));
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		tick_ch.valid <= 1'b1;
		tick_ch.restart <= restart;
		do @(posedge clk); while (!tick_ch.ready);
		sent_ticks++;
	endtask

	// stop sending and let the pipe run dry before touching registers
	task automatic settle();
		rest(1);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] tw, input logic [31:0] po,
		input logic [31:0] amp, input logic [31:0] mode, input logic [31:0] count);
		write_reg(REG_TUNING_WORD, tw);
		write_reg(REG_PHASE_OFFSET, po);
		write_reg(REG_AMPLITUDE, amp);
		write_reg(REG_WAVE_MODE, mode);
		write_reg(REG_SAMPLE_COUNT, count);
	endtask

	task automatic tone_run(input int ticks, input logic restart_first);
		for (int n = 0; n < ticks; n++) begin
			send_tick((n == 0) ? restart_first : 1'b0);
		end
	endtask

	// sample sink: long hold on request, otherwise a changing stall pattern
	initial begin
		int style;
		int span;
		int cyc;
		style = 0;
		span = 0;
		cyc = 0;
		sample_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_req) begin
				sample_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (span == 0) begin
					style = $urandom_range(0, 3);
					span = $urandom_range(16, 96);
				end
				span--;
				case (style)
					0: sample_ch.ready <= 1'b1;
					1: sample_ch.ready <= 1'($urandom);
					2: sample_ch.ready <= ($urandom_range(0, 9) != 0);
					default: sample_ch.ready <= (cyc % 3 != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_ch.valid && tick_ch.ready) || (sample_ch.valid && sample_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("** tone_waveform_generator_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int          phase_no;
		int          n_ticks;
		logic [31:0] value;
		logic [23:0] cur_count;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.restart = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_TUNING_WORD;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// quarter-turn steps hit zero, both peaks and the zero crossings;
		// writes go in while the table is still loading
		configure(32'h4000_0000, 32'h0, 32'd32767, 32'(WAVE_SINE), 32'd6);
		write_reg(REG_NONE_LO, 32'hFFFF_FFFF);
		tone_run(8, 1'b1);

		// finished run ignores ticks, then square with a zero sine
		settle();
		write_reg(REG_WAVE_MODE, 32'(WAVE_SQUARE));
		tone_run(1, 1'b0);
		tone_run(4, 1'b1);

		// everything masked down: amplitude zero, sine, three samples
		settle();
		configure(32'hFFFF_FFFF, 32'hFFFF_C000, 32'hFFFF_0000, 32'hFFFF_FFFE,
			32'hFF00_0003);
		tone_run(4, 1'b1);

		// zero length, then a finished run that a new length does not reopen
		settle();
		write_reg(REG_AMPLITUDE, 32'd1);
		write_reg(REG_SAMPLE_COUNT, 32'd0);
		tone_run(1, 1'b1);
		settle();
		write_reg(REG_SAMPLE_COUNT, 32'd5);
		tone_run(1, 1'b0);
		settle();
		configure(32'h0123_4567, 32'h0000_4000, 32'd1, 32'(WAVE_SQUARE), 32'd5);
		tone_run(3, 1'b1);
		// length shrunk below the index mid-run
		settle();
		write_reg(REG_SAMPLE_COUNT, 32'd2);
		tone_run(1, 1'b0);

		phase_no = 0;
		cur_count = 24'd2;
		while (sent_ticks < TARGET_TICKS) begin
			settle();
			gappy = ($urandom_range(0, 9) < 7);
			burst_left = 0;
			if (phase_no == 0 || $urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 5))
					0: value = 32'h0;
					1: value = 32'hFFFF_FFFF;
					2: value = $urandom_range(0, 32'h000F_FFFF);
					3: value = {2'($urandom), 30'h0};
					default: value = $urandom;
				endcase
				write_reg(REG_TUNING_WORD, value);
			end
			if (phase_no == 0 || $urandom_range(0, 9) < 5) begin
				case ($urandom_range(0, 4))
					0: value = 32'h0;
					1: value = 32'h0000_FFFF;
					2: value = {16'h0, 2'($urandom), 14'h0};
					default: value = 32'($urandom_range(0, 16'hFFFF));
				endcase
				write_reg(REG_PHASE_OFFSET, pad_junk(value, 16));
			end
			if (phase_no == 0 || $urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 4))
					0: value = 32'h0;
					1: value = 32'(PEAK_SAMPLE);
					default: value = 32'($urandom_range(0, PEAK_SAMPLE));
				endcase
				write_reg(REG_AMPLITUDE, pad_junk(value, 15));
			end
			if (phase_no == 0 || $urandom_range(0, 9) < 6) begin
				write_reg(REG_WAVE_MODE, pad_junk(32'($urandom_range(0, 1)), 1));
			end
			if (phase_no == 0 || $urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 19))
					0: cur_count = 24'h0;
					1: cur_count = 24'hFF_FFFF;
					2: cur_count = 24'($urandom);
					default: cur_count = 24'($urandom_range(1, 40));
				endcase
				write_reg(REG_SAMPLE_COUNT, pad_junk({8'h0, cur_count}, 24));
			end
			if ($urandom_range(0, 4) == 0) begin
				write_reg(REG_NONE_LO + 3'($urandom_range(0, 2)), $urandom);
			end
			// sink holds off while ticks keep coming back to back
			if (phase_no == 3) begin
				cur_count = 24'd48;
				write_reg(REG_SAMPLE_COUNT, 32'(cur_count));
				gappy = 1'b0;
				hold_req = 1'b1;
			end
			n_ticks = ((cur_count > 24'd60) ? 60 : int'(cur_count)) + $urandom_range(0, 2);
			if (n_ticks == 0) begin
				n_ticks = 1;
			end
			for (int n = 0; n < n_ticks; n++) begin
				send_tick((n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 99) < 3));
			end
			phase_no++;
		end

		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("** tone_waveform_generator_top: PASSED **");
		end else begin
			$display("** tone_waveform_generator_top: FAILED **");
		end
		$finish;
	end

endmodule

[files.f]
sv/twg_pkg.sv
sv/twg_intf.sv
sv/twg_ram.sv
sv/twg_ctrl.sv
sv/twg_shape.sv
sv/tone_waveform_generator_top.sv
verif/twg_tb_pkg.sv
verif/twg_checker.sv
verif/tb_tone_waveform_generator_top.sv
